FILE: hw/rtl/seven_segment_command_encoder_assert.svh
// assertion macros for the seven-segment command encoder
// expects clk and rst_n in the scope of each use
`ifndef SEVEN_SEGMENT_COMMAND_ENCODER_ASSERT_SVH
`define SEVEN_SEGMENT_COMMAND_ENCODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SSCE_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SSCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ssce_pkg.sv
// shared constants and types of the seven-segment command encoder
// no dependencies
`default_nettype none

package ssce_pkg;

    localparam int NUM_DOTS  = 6;
    localparam int DOT_IDX_W = (NUM_DOTS > 1) ? $clog2(NUM_DOTS) : 1;

    localparam logic [7:0] CMD_CURSOR = 8'h79;
    localparam logic [7:0] CMD_DOTS   = 8'h77;
    localparam logic [7:0] CMD_CLEAR  = 8'h76;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    localparam logic [1:0] MODE_NUMBER = 2'd0;
    localparam logic [1:0] MODE_CHAR   = 2'd1;
    localparam logic [1:0] MODE_DOT    = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic signed [31:0] NUM_MAX = 32'sd180;
    localparam logic signed [31:0] NUM_MIN = -32'sd180;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // one classified command waiting for the byte sequencer
    typedef struct packed {
        logic [1:0]          mode;
        logic [2:0]          position;
        logic [3:0][7:0]     chars;
        logic [NUM_DOTS-1:0] mask;
    } ssce_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ssce_q_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ssce_if.sv
// handshake channels of the seven-segment command encoder
// command channel in, display byte channel out; no dependencies
`default_nettype none

interface ssce_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] number;
    logic [7:0]         char_value;
    logic [2:0]         position;
    logic               dot_on;

    modport source (output valid, mode, number, char_value, position, dot_on, input ready);
    modport sink (input valid, mode, number, char_value, position, dot_on, output ready);
endinterface

interface ssce_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/seven_segment_command_encoder.sv
// top level of the seven-segment command encoder
// depends on ssce_pkg, ssce_if, ssce_front, ssce_queue, ssce_back and the assert header
`default_nettype none

`include "seven_segment_command_encoder_assert.svh"

// Takes display commands on cmd and sends the serial byte stream for a 4-digit
// seven-segment module on disp, one byte per clock while disp is ready. A number
// command gives 12 bytes, a character command 3, a dot command 2 and a clear
// command 1, all sent by the single byte sequencer through its output register.
// The front end renders the command and updates the dot mask in the accept
// cycle and writes it into a two-entry queue; the command being sent keeps its
// entry until its last byte is loaded, so one more command waits behind it.
// The first byte of a command is registered in the queue entry and then in the
// output register before it is presented on disp; the last byte of each command
// is flagged with last.
module seven_segment_command_encoder (
    input  wire         clk,
    input  wire         rst_n,
    ssce_cmd_if.sink    cmd,
    ssce_byte_if.source disp
);
    import ssce_pkg::*;

    ssce_entry_t  push_entry;
    ssce_entry_t  head;
    ssce_q_stat_t q_stat;
    logic         push;
    logic         pop;

    ssce_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_stat (q_stat),
        .push   (push),
        .entry  (push_entry)
    );

    ssce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    ssce_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .disp   (disp)
    );

    `SSCE_ASSERT_IMPLY(a_no_push_full, push, !q_stat.full, "item pushed into full queue")
    `SSCE_ASSERT_IMPLY(a_no_pop_empty, pop, !q_stat.empty, "pop from empty queue")
    `SSCE_ASSERT_NEXT(a_pop_shows_last, pop, disp.valid && disp.last, "pop without last byte shown")

endmodule

`default_nettype wire

FILE: hw/rtl/ssce_front.sv
// front end: accepts commands, renders numbers to characters, keeps the dot mask
// depends on ssce_pkg and ssce_if
`default_nettype none

module ssce_front (
    input  wire                   clk,
    input  wire                   rst_n,
    ssce_cmd_if.sink              cmd,
    input  ssce_pkg::ssce_q_stat_t q_stat,
    output logic                  push,
    output ssce_pkg::ssce_entry_t entry
);
    import ssce_pkg::*;

    logic [NUM_DOTS-1:0] dot_mask_reg;
    logic [NUM_DOTS-1:0] dot_mask_next;
    logic                accept;
    logic signed [8:0]   clamp_v;
    logic                neg;
    logic [7:0]          mag;
    logic                hund;
    logic [6:0]          rem;
    logic [17:0]         tprod;
    logic [3:0]          tens;
    logic [6:0]          ten_x;
    logic [3:0]          ones;
    logic [3:0][7:0]     num_chars;

    assign cmd.ready = !q_stat.full;
    assign accept    = cmd.valid && cmd.ready;
    assign push      = accept;

    // clamp and split into decimal digits, magnitude is at most 180
    always_comb
    begin
        if (cmd.number > NUM_MAX)
        begin
            clamp_v = 9'sd180;
        end
        else if (cmd.number < NUM_MIN)
        begin
            clamp_v = -9'sd180;
        end
        else
        begin
            clamp_v = cmd.number[8:0];
        end
        neg   = clamp_v[8];
        mag   = neg ? 8'(-clamp_v) : clamp_v[7:0];
        hund  = (mag >= 8'd100);
        rem   = 7'(hund ? (mag - 8'd100) : mag);
        // divide by ten via reciprocal, exact below 1029
        tprod = 18'(rem) * 18'd205;
        tens  = 4'(tprod >> 11);
        ten_x = 7'({3'b000, tens} * 7'd10);
        ones  = 4'(rem - ten_x);

        num_chars[0] = (neg && hund) ? CH_MINUS : CH_ZERO;
        num_chars[1] = (neg && !hund && (mag >= 8'd10)) ? CH_MINUS
                                                         : (CH_ZERO + 8'(hund));
        num_chars[2] = (neg && (mag < 8'd10)) ? CH_MINUS : (CH_ZERO + 8'(tens));
        num_chars[3] = CH_ZERO + 8'(ones);
    end

    always_comb
    begin
        dot_mask_next = dot_mask_reg;
        if (accept && (cmd.mode == MODE_DOT) && ({1'b0, cmd.position} < 4'(NUM_DOTS)))
        begin
            dot_mask_next[cmd.position[DOT_IDX_W-1:0]] = cmd.dot_on;
        end
    end

    always_comb
    begin
        entry.mode     = cmd.mode;
        entry.position = cmd.position;
        entry.mask     = dot_mask_next;
        if (cmd.mode == MODE_NUMBER)
        begin
            entry.chars = num_chars;
        end
        else
        begin
            entry.chars    = '0;
            entry.chars[0] = cmd.char_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_mask_reg <= '0;
        end
        else
        begin
            dot_mask_reg <= dot_mask_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ssce_queue.sv
// short command queue between the front end and the byte sequencer
// depends on ssce_pkg
`default_nettype none

module ssce_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  ssce_pkg::ssce_entry_t  push_entry,
    input  wire                    pop,
    output ssce_pkg::ssce_entry_t  head,
    output ssce_pkg::ssce_q_stat_t q_stat
);
    import ssce_pkg::*;

    ssce_entry_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ssce_back.sv
// byte sequencer: walks the head command into an output register, one byte per
// cycle while that register is free; depends on ssce_pkg and ssce_if
`default_nettype none

module ssce_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  ssce_pkg::ssce_entry_t  head,
    input  ssce_pkg::ssce_q_stat_t q_stat,
    output logic                   pop,
    ssce_byte_if.source            disp
);
    import ssce_pkg::*;

    logic [1:0] grp_reg;
    logic [1:0] sub_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       load;
    logic [7:0] byte_val;
    logic       byte_last;

    assign disp.valid    = out_valid_reg;
    assign disp.out_byte = out_byte_reg;
    assign disp.last     = out_last_reg;

    assign load = (!out_valid_reg || disp.ready) && !q_stat.empty;
    assign pop  = load && byte_last;

    // sub_reg picks the byte within a three-byte cursor group, grp_reg the group
    always_comb
    begin
        byte_val  = '0;
        byte_last = 1'b0;
        case (head.mode)
            MODE_NUMBER, MODE_CHAR:
            begin
                case (sub_reg)
                    2'd0:
                    begin
                        byte_val = CMD_CURSOR;
                    end
                    2'd1:
                    begin
                        byte_val = (head.mode == MODE_NUMBER) ? {6'b0, grp_reg}
                                                              : {5'b0, head.position};
                    end
                    2'd2:
                    begin
                        byte_val  = head.chars[grp_reg];
                        byte_last = (head.mode == MODE_CHAR) || (grp_reg == 2'd3);
                    end
                    default:
                    begin
                        byte_val  = '0;
                        byte_last = 1'b1;
                    end
                endcase
            end
            MODE_DOT:
            begin
                byte_val  = (sub_reg == 2'd0) ? CMD_DOTS : 8'(head.mask);
                byte_last = (sub_reg != 2'd0);
            end
            default:
            begin
                byte_val  = CMD_CLEAR;
                byte_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_reg       <= '0;
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                if (byte_last)
                begin
                    grp_reg <= '0;
                    sub_reg <= '0;
                end
                else if (sub_reg == 2'd2)
                begin
                    grp_reg <= grp_reg + 1'b1;
                    sub_reg <= '0;
                end
                else
                begin
                    sub_reg <= sub_reg + 1'b1;
                end
            end
            else if (disp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_val;
            out_last_reg <= byte_last;
        end
    end

endmodule

`default_nettype wire
